// File: design/dhcp_oar_pkg.sv
// Package for the DHCP offer/ack responder.
// Holds the item structs, status and phase codes and fixed constants.
// No dependencies.
package dhcp_oar_pkg;

  localparam int unsigned HwAddrBytes = 16;
  localparam int unsigned HwIdxW      = $clog2(HwAddrBytes);
  localparam logic [9:0]  MsgLast     = 10'd547;
  localparam logic [9:0]  OptBase     = 10'd240;
  localparam logic [9:0]  MsgLen      = 10'd548;
  localparam logic [9:0]  OptCodeEnd  = 10'd546;
  localparam logic [9:0]  HwAddrBase  = 10'd28;
  localparam logic [8:0]  SkipMark    = 9'd256;
  localparam logic [7:0]  OctetLimit  = 8'd254;

  localparam logic [0:0] CfgServerIp   = 1'b0;
  localparam logic [0:0] CfgSubnetMask = 1'b1;

  typedef enum logic [2:0] {
    StOffer   = 3'd0,
    StAck     = 3'd1,
    StShort   = 3'd2,
    StBadOp   = 3'd3,
    StBadMag  = 3'd4,
    StBadType = 3'd5,
    StNone    = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    PhCode = 2'd0,
    PhLen  = 2'd1,
    PhBody = 2'd2,
    PhDone = 2'd3
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
    logic       rx_last;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [2:0] status;
    logic [7:0] assigned_octet;
    logic [7:0] reply_byte;
    logic       reply_last;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    logic     has_result;
  } cls_item_t;

  function automatic logic [7:0] octet_of(logic [31:0] word, logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0:    r = word[31:24];
      2'd1:    r = word[23:16];
      2'd2:    r = word[15:8];
      default: r = word[7:0];
    endcase
    return r;
  endfunction

endpackage

// File: design/dhcp_oar_front.sv
// Front part: accepts input items, tags those that yield a result, queues them.
// Depends on dhcp_oar_pkg.
module dhcp_oar_front
  import dhcp_oar_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      head_valid_o,
  output cls_item_t head_o,
  input  logic      pop_i
);

  cls_item_t  mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, wr_d, rd_q, rd_d;
  logic       push;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{item: in_item_i, has_result: in_item_i.kind | in_item_i.rx_last};
    end
  end

endmodule

// File: design/dhcp_oar_back.sv
// Back part: parses request bytes, holds the reply state and emits results.
// Depends on dhcp_oar_pkg.
module dhcp_oar_back
  import dhcp_oar_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] server_ip_i,
  input  logic [31:0] subnet_mask_i,
  input  logic        head_valid_i,
  input  cls_item_t   head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  logic [9:0]  rx_off_q, rx_off_d, tx_q, tx_d;
  logic [8:0]  skip_q, skip_d;
  phase_e      ph_q, ph_d;
  logic [7:0]  ftype_q, ftype_d, next_oct_q, next_oct_d, given_q, given_d;
  logic        op_q, op_d, mag_q, mag_d, pend_q, pend_d, ack_q, ack_d;
  logic [7:0]  hw_type_q, hw_len_q;
  logic [31:0] xid_q;
  logic [15:0] flags_q;
  logic [7:0]  chaddr_q [HwAddrBytes];
  logic [9:0]  hw_off;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic        fire, rx_fire;
  logic [7:0]  b, rbyte, cookie_b;
  logic [9:0]  pos;
  logic [9:0]  t;
  logic [9:0]  tm;

  assign b       = head_i.item.rx_byte;
  assign fire    = head_valid_i && (!head_i.has_result || !out_valid_q || !out_stall_i);
  assign pop_o   = fire;
  assign rx_fire = fire && !head_i.item.kind;
  assign pos     = rx_off_q - OptBase;
  assign hw_off  = rx_off_q - HwAddrBase;
  assign t       = tx_q;
  assign tm      = t - HwAddrBase;

  always_comb begin
    case (rx_off_q[1:0])
      2'd0:    cookie_b = 8'd99;
      2'd1:    cookie_b = 8'd130;
      2'd2:    cookie_b = 8'd83;
      default: cookie_b = 8'd99;
    endcase
  end

  always_comb begin
    rbyte = 8'd0;
    if (t == 10'd0) rbyte = 8'd2;
    else if (t == 10'd1) rbyte = hw_type_q;
    else if (t == 10'd2) rbyte = hw_len_q;
    else if (t >= 10'd4 && t <= 10'd7) rbyte = octet_of(xid_q, t[1:0]);
    else if (t == 10'd10) rbyte = flags_q[15:8];
    else if (t == 10'd11) rbyte = flags_q[7:0];
    else if (t >= 10'd16 && t <= 10'd18) rbyte = octet_of(server_ip_i, t[1:0]);
    else if (t == 10'd19) rbyte = given_q;
    else if (t >= 10'd20 && t <= 10'd23) rbyte = octet_of(server_ip_i, t[1:0]);
    else if (t >= 10'd28 && t < 10'd44) rbyte = chaddr_q[tm[HwIdxW-1:0]];
    else if (t == 10'd236 || t == 10'd239) rbyte = 8'd99;
    else if (t == 10'd237) rbyte = 8'd130;
    else if (t == 10'd238) rbyte = 8'd83;
    else if (t == 10'd240) rbyte = 8'd53;
    else if (t == 10'd241) rbyte = 8'd1;
    else if (t == 10'd242) rbyte = ack_q ? 8'd5 : 8'd2;
    else if (t == 10'd243) rbyte = 8'd54;
    else if (t == 10'd249) rbyte = 8'd51;
    else if (t == 10'd255) rbyte = 8'd1;
    else if (t == 10'd261) rbyte = 8'd3;
    else if (t == 10'd267) rbyte = 8'd6;
    else if (t == 10'd244 || t == 10'd250 || t == 10'd256 || t == 10'd262 || t == 10'd268)
      rbyte = 8'd4;
    else if (t >= 10'd245 && t <= 10'd248) rbyte = octet_of(server_ip_i, 2'(t - 10'd245));
    else if (t == 10'd251) rbyte = 8'h00;
    else if (t == 10'd252) rbyte = 8'h01;
    else if (t == 10'd253) rbyte = 8'h51;
    else if (t == 10'd254) rbyte = 8'h80;
    else if (t >= 10'd257 && t <= 10'd260) rbyte = octet_of(subnet_mask_i, 2'(t - 10'd257));
    else if (t >= 10'd263 && t <= 10'd266) rbyte = octet_of(server_ip_i, 2'(t - 10'd263));
    else if (t >= 10'd269 && t <= 10'd272) rbyte = octet_of(server_ip_i, 2'(t - 10'd269));
    else if (t == 10'd273) rbyte = 8'd255;
  end

  always_comb begin
    rx_off_d   = rx_off_q;
    skip_d     = skip_q;
    ph_d       = ph_q;
    ftype_d    = ftype_q;
    op_d       = op_q;
    mag_d      = mag_q;
    next_oct_d = next_oct_q;
    pend_d     = pend_q;
    ack_d      = ack_q;
    given_d    = given_q;
    tx_d       = tx_q;
    out_d      = out_q;
    out_valid_d = out_stall_i ? out_valid_q : 1'b0;
    if (rx_fire) begin
      if (rx_off_q == 10'd0) op_d = (b == 8'd1);
      if (rx_off_q >= 10'd236 && rx_off_q <= 10'd239) begin
        mag_d = (rx_off_q == 10'd236) ? (b == cookie_b) : (mag_q && (b == cookie_b));
      end
      if (rx_off_q >= OptBase && rx_off_q < MsgLen) begin
        unique case (ph_q)
          PhCode: begin
            if (pos >= (OptCodeEnd - OptBase) || b == 8'd255) begin
              ph_d = PhDone;
            end else if (b == 8'd53) begin
              skip_d = SkipMark;
              ph_d   = PhLen;
            end else if (b != 8'd0) begin
              skip_d = 9'd0;
              ph_d   = PhLen;
            end
          end
          PhLen: begin
            if (skip_q == SkipMark) begin
              ph_d = PhBody;
            end else begin
              skip_d = {1'b0, b};
              ph_d   = (b == 8'd0) ? PhCode : PhBody;
            end
          end
          PhBody: begin
            if (skip_q == SkipMark) begin
              ftype_d = b;
              ph_d    = PhDone;
            end else begin
              skip_d = skip_q - 9'd1;
              if (skip_q == 9'd1) ph_d = PhCode;
            end
          end
          default: ph_d = PhDone;
        endcase
      end
      if (rx_off_q != 10'h3FF) rx_off_d = rx_off_q + 10'd1;
      if (head_i.item.rx_last) begin
        out_valid_d = 1'b1;
        out_d = '0;
        if (rx_off_d < OptBase) out_d.status = StShort;
        else if (!op_d) out_d.status = StBadOp;
        else if (!mag_d) out_d.status = StBadMag;
        else if (ftype_d != 8'd1 && ftype_d != 8'd3) out_d.status = StBadType;
        else begin
          ack_d = (ftype_d == 8'd3);
          out_d.status = ack_d ? StAck : StOffer;
          given_d = next_oct_q;
          out_d.assigned_octet = next_oct_q;
          if (next_oct_q < OctetLimit) next_oct_d = next_oct_q + 8'd1;
          pend_d = 1'b1;
          tx_d   = 10'd0;
        end
        rx_off_d = 10'd0;
        skip_d   = 9'd0;
        ph_d     = PhCode;
        ftype_d  = 8'd0;
        op_d     = 1'b0;
        mag_d    = 1'b0;
      end
    end else if (fire) begin
      out_valid_d = 1'b1;
      out_d = '0;
      out_d.result_kind = 1'b1;
      if (!pend_q) begin
        out_d.status = StNone;
      end else begin
        out_d.status         = ack_q ? StAck : StOffer;
        out_d.assigned_octet = given_q;
        out_d.reply_byte     = rbyte;
        if (tx_q >= MsgLast) begin
          out_d.reply_last = 1'b1;
          pend_d = 1'b0;
          tx_d   = 10'd0;
        end else begin
          tx_d = tx_q + 10'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_off_q    <= 10'd0;
      skip_q      <= 9'd0;
      ph_q        <= PhCode;
      ftype_q     <= 8'd0;
      op_q        <= 1'b0;
      mag_q       <= 1'b0;
      next_oct_q  <= 8'd2;
      pend_q      <= 1'b0;
      ack_q       <= 1'b0;
      given_q     <= 8'd0;
      tx_q        <= 10'd0;
      out_valid_q <= 1'b0;
    end else begin
      rx_off_q    <= rx_off_d;
      skip_q      <= skip_d;
      ph_q        <= ph_d;
      ftype_q     <= ftype_d;
      op_q        <= op_d;
      mag_q       <= mag_d;
      next_oct_q  <= next_oct_d;
      pend_q      <= pend_d;
      ack_q       <= ack_d;
      given_q     <= given_d;
      tx_q        <= tx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (rx_fire) begin
      if (rx_off_q == 10'd1) hw_type_q <= b;
      if (rx_off_q == 10'd2) hw_len_q <= b;
      if (rx_off_q == 10'd4) xid_q[31:24] <= b;
      if (rx_off_q == 10'd5) xid_q[23:16] <= b;
      if (rx_off_q == 10'd6) xid_q[15:8] <= b;
      if (rx_off_q == 10'd7) xid_q[7:0] <= b;
      if (rx_off_q == 10'd10) flags_q[15:8] <= b;
      if (rx_off_q == 10'd11) flags_q[7:0] <= b;
      if (rx_off_q >= HwAddrBase && rx_off_q < 10'd44) chaddr_q[hw_off[HwIdxW-1:0]] <= b;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: design/dhcp_offer_ack_responder.sv
// Top level of the DHCP offer/ack responder: configuration registers,
// front queue and back engine. Depends on dhcp_oar_pkg, dhcp_oar_front, dhcp_oar_back.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid_i/in_stall_o   | in_item_i (in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (out_item_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item is taken per cycle while in_stall_o is low; the result of an item that yields one is
// registered when the item leaves the two-entry queue and appears in the next cycle.
// Reset clears parse and reply state; header and hardware address bytes are not reset.
// A stalled result holds the engine only for items that produce a result.
module dhcp_offer_ack_responder
  import dhcp_oar_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] server_ip_q, subnet_mask_q;
  logic        head_valid, pop;
  cls_item_t   head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_ip_q   <= 32'd0;
      subnet_mask_q <= 32'hFFFF_FF00;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgServerIp:   server_ip_q   <= cfg_data_i;
        CfgSubnetMask: subnet_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dhcp_oar_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_item_i,
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  dhcp_oar_back u_back (
    .clk_i,
    .rst_ni,
    .server_ip_i   (server_ip_q),
    .subnet_mask_i (subnet_mask_q),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o,
    .out_stall_i,
    .out_item_o
  );

endmodule

// File: tb/testbench.sv
// Testbench for dhcp_offer_ack_responder: directed table, then random DHCP payloads and pulls.
// Results are checked against a behavioral predictor in this file.
// Depends on dhcp_oar_pkg and the RTL of the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dhcp_oar_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = CfgServerIp;
  logic [31:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  dhcp_offer_ack_responder i_dut (.*);

  // Predictor state.
  logic [31:0] srv_ip, mask;
  int unsigned rx_off, skip, given, nxt, tx_off;
  phase_e ph;
  logic [7:0] ftype, htype, hlen;
  logic op_good, mag_good, pending, is_ack;
  logic [31:0] xid;
  logic [15:0] flags;
  logic [7:0] chaddr [HwAddrBytes];

  out_item_t replies_due[$];
  int errors = 0, n_items = 0, n_results = 0, n_offers = 0, idle_send = 0, idle_recv = 0;
  int quiet = 0;

  function automatic logic [7:0] oct(logic [31:0] w, int k);
    return w[31-8*k -: 8];
  endfunction

  function automatic logic [7:0] reply_octet(int t);
    case (t)
      0: return 8'd2;
      1: return htype;
      2: return hlen;
      10: return flags[15:8];
      11: return flags[7:0];
      19: return given[7:0];
      236, 239: return 8'd99;
      237: return 8'd130;
      238: return 8'd83;
      240: return 8'd53;
      241, 255: return 8'd1;
      242: return is_ack ? 8'd5 : 8'd2;
      243: return 8'd54;
      249: return 8'd51;
      261: return 8'd3;
      267: return 8'd6;
      244, 250, 256, 262, 268: return 8'd4;
      251: return 8'h00;
      252: return 8'h01;
      253: return 8'h51;
      254: return 8'h80;
      273: return 8'd255;
      default: ;
    endcase
    if (t >= 4 && t <= 7) return oct(xid, t - 4);
    if (t >= 16 && t <= 18) return oct(srv_ip, t - 16);
    if (t >= 20 && t <= 23) return oct(srv_ip, t - 20);
    if (t >= 28 && t < 44) return chaddr[t-28];
    if (t >= 245 && t <= 248) return oct(srv_ip, t - 245);
    if (t >= 257 && t <= 260) return oct(mask, t - 257);
    if (t >= 263 && t <= 266) return oct(srv_ip, t - 263);
    if (t >= 269 && t <= 272) return oct(srv_ip, t - 269);
    return 8'd0;
  endfunction

  task automatic walk(int pos, logic [7:0] b);
    case (ph)
      PhCode: begin
        if (pos >= 306 || b == 8'd255) ph = PhDone;
        else if (b == 8'd53) begin skip = 256; ph = PhLen; end
        else if (b != 0) begin skip = 0; ph = PhLen; end
      end
      PhLen: begin
        if (skip == 256) ph = PhBody;
        else begin skip = b; ph = (b == 0) ? PhCode : PhBody; end
      end
      PhBody: begin
        if (skip == 256) begin ftype = b; ph = PhDone; end
        else begin skip = (skip - 1) & 9'h1ff; if (skip == 0) ph = PhCode; end
      end
      default: ;
    endcase
  endtask

  task automatic clear_parse();
    rx_off = 0; skip = 0; ph = PhCode; ftype = 0; op_good = 0; mag_good = 0;
  endtask

  task automatic predict(in_item_t it);
    logic [7:0] ck [4];
    out_item_t r;
    status_e st;
    int o;
    ck = '{8'd99, 8'd130, 8'd83, 8'd99};
    r = '0;
    if (!it.kind) begin
      o = rx_off;
      if (o == 0) op_good = (it.rx_byte == 8'd1);
      else if (o == 1) htype = it.rx_byte;
      else if (o == 2) hlen = it.rx_byte;
      else if (o >= 4 && o <= 7) xid[8*(7-o) +: 8] = it.rx_byte;
      else if (o == 10) flags[15:8] = it.rx_byte;
      else if (o == 11) flags[7:0] = it.rx_byte;
      else if (o >= 28 && o < 44) chaddr[o-28] = it.rx_byte;
      else if (o >= 236 && o <= 239)
        mag_good = (it.rx_byte == ck[o-236]) && (o == 236 || mag_good);
      else if (o >= 240 && o < 548) walk(o - 240, it.rx_byte);
      if (rx_off < 1023) rx_off++;
      if (!it.rx_last) return;
      if (rx_off < 240) st = StShort;
      else if (!op_good) st = StBadOp;
      else if (!mag_good) st = StBadMag;
      else if (ftype != 1 && ftype != 3) st = StBadType;
      else begin
        is_ack = (ftype == 3);
        st = is_ack ? StAck : StOffer;
        given = nxt;
        r.assigned_octet = given[7:0];
        if (nxt < 254) nxt++;
        pending = 1; tx_off = 0; n_offers++;
      end
      r.status = st;
      clear_parse();
    end else begin
      r.result_kind = 1'b1;
      if (!pending) r.status = StNone;
      else begin
        r.status = is_ack ? StAck : StOffer;
        r.assigned_octet = given[7:0];
        r.reply_byte = reply_octet(tx_off);
        if (tx_off >= 547) begin r.reply_last = 1; pending = 0; tx_off = 0; end
        else tx_off++;
      end
    end
    replies_due.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 30) $display("mismatch in %s: got %0d, expected %0d", what, got, want);
  endtask

  // Result checking.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_item_t w;
      n_results++;
      if (replies_due.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        w = replies_due.pop_front();
        if (out_item_o.result_kind !== w.result_kind)
          report_mismatch("result_kind", out_item_o.result_kind, w.result_kind);
        if (out_item_o.status !== w.status)
          report_mismatch("status", out_item_o.status, w.status);
        if (out_item_o.assigned_octet !== w.assigned_octet)
          report_mismatch("assigned_octet", out_item_o.assigned_octet, w.assigned_octet);
        if (out_item_o.reply_byte !== w.reply_byte)
          report_mismatch("reply_byte", out_item_o.reply_byte, w.reply_byte);
        if (out_item_o.reply_last !== w.reply_last)
          report_mismatch("reply_last", out_item_o.reply_last, w.reply_last);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("dhcp_offer_ack_responder test failed");
      $finish;
    end
  end

  // Receiver stall pattern.
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < idle_recv);

  task automatic send(in_item_t it);
    while ($urandom_range(99) < idle_send) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict(it);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic rx(logic [7:0] b, logic l);
    in_item_t it;
    it.kind = 1'b0; it.rx_byte = b; it.rx_last = l;
    send(it);
  endtask

  task automatic pull();
    in_item_t it;
    it.kind = 1'b1; it.rx_byte = 8'($urandom); it.rx_last = 1'($urandom);
    send(it);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] d);
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgServerIp) srv_ip = d; else mask = d;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One payload; mode 0 well formed, though bytes 244 to 246 are at times made random, others break one check.
  task automatic payload(int mode, logic [7:0] mtype);
    int len, pos;
    logic [7:0] b;
    len = (mode == 1) ? $urandom_range(1, 40) : $urandom_range(247, 252);
    pos = 0;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == 0) b = (mode == 2) ? 8'($urandom_range(2, 255)) : 8'd1;
      else if (i >= 236 && i <= 239) begin
        b = (i == 237) ? 8'd130 : (i == 238) ? 8'd83 : 8'd99;
        if (mode == 3 && i == 238) b = 8'd84;
      end else if (i >= 240) begin
        if (mode == 4) b = (i == 240) ? 8'd255 : b;
        else if (i == 240) b = 8'd12;
        else if (i == 241) b = 8'd1;
        else if (i == 243) b = 8'd0;
        else if (i == 244) b = 8'd53;
        else if (i == 245) b = 8'd1;
        else if (i == 246) b = mtype;
        if (i >= 244 && i <= 246 && mode == 0 && $urandom_range(15) == 0) b = 8'($urandom);
      end
      rx(b, i == len - 1);
    end
  endtask

  task automatic drain(int k);
    for (int i = 0; i < k; i++) pull();
  endtask

  typedef struct { int mode; logic [7:0] mtype; int pulls; logic chk; status_e want; } row_t;
  row_t rows[7];

  initial begin
    srv_ip = '0; mask = 32'hffffff00; clear_parse(); nxt = 2; pending = 0; is_ack = 0;
    given = 0; tx_off = 0; htype = 0; hlen = 0; xid = 0; flags = 0;
    foreach (chaddr[i]) chaddr[i] = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    rows = '{'{9, 0, 1, 1, StNone}, '{1, 1, 0, 1, StShort}, '{2, 1, 0, 1, StBadOp},
             '{3, 1, 0, 1, StBadMag}, '{4, 7, 0, 1, StBadType}, '{0, 1, 10, 0, StOffer},
             '{0, 3, 4, 0, StAck}};
    foreach (rows[r]) begin
      if (rows[r].mode != 9) payload(rows[r].mode, rows[r].mtype);
      if (rows[r].chk && rows[r].mode != 9 && replies_due[$].status !== rows[r].want)
        report_mismatch("directed status", replies_due[$].status, rows[r].want);
      drain(rows[r].pulls);
    end
    write_reg(CfgServerIp, 32'hffffffff);
    write_reg(CfgSubnetMask, 32'h0);
    for (int p = 0; p < 4; p++) begin
      idle_send = (p == 1 || p == 3) ? (p == 3 ? 37 : 48) : 0;
      idle_recv = (p == 2 || p == 3) ? (p == 3 ? 37 : 48) : 0;
      payload(1, 8'd1);
      drain(137);
      write_reg(CfgServerIp, p[0] ? $urandom : 32'h0);
      write_reg(CfgSubnetMask, p[1] ? $urandom : 32'hffffffff);
    end
    idle_send = 0; idle_recv = 0;
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("Ran %0d items, %0d results checked, %0d replies queued.",
             n_items, n_results, n_offers);
    if (errors == 0) $display("dhcp_offer_ack_responder test passed");
    else $display("dhcp_offer_ack_responder test failed");
    $finish;
  end
endmodule

// File: dhcp_offer_ack_responder.f
design/dhcp_oar_pkg.sv
design/dhcp_oar_front.sv
design/dhcp_oar_back.sv
design/dhcp_offer_ack_responder.sv
tb/testbench.sv
